>>> design/lkvc_pkg.sv
`default_nettype none
package lkvc_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 4;
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd3;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	localparam int S_TDATA_W = KEY_W + VAL_W;
	localparam int M_TDATA_W = VAL_W + KEY_W;
	localparam int M_TUSER_W = 2;
	localparam int TU_HIT     = 0;
	localparam int TU_EVICTED = 1;

	typedef struct packed {
		logic load;
		logic cmp;
		logic rd;
		logic upd;
	} cmd_t;

endpackage
`default_nettype wire

>>> design/lkvc_ctrl.sv
`default_nettype none
module lkvc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output lkvc_pkg::cmd_t     cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_UPD  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       m_tvalid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp   = 1'b1;
				state_nxt = ST_RD;
			end
			ST_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = ST_UPD;
			end
			ST_UPD: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.upd   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.upd) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule
`default_nettype wire

>>> design/lkvc_dpath.sv
`default_nettype none
module lkvc_dpath #(
	parameter int ENTRIES  = 8,
	parameter int KEY_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lkvc_pkg::cmd_t                    cmd,
	input  wire logic                              cfg_valid,
	input  wire logic [lkvc_pkg::CAP_W-1:0]        cfg_data,
	input  wire logic [lkvc_pkg::S_TDATA_W-1:0]    s_tdata,
	input  wire logic                              s_tuser,
	output logic      [lkvc_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic      [lkvc_pkg::M_TUSER_W-1:0]    m_tuser
);

	localparam int IW = $clog2(ENTRIES);
	localparam int OW = $clog2(ENTRIES + 1);
	localparam int KW = lkvc_pkg::KEY_W;
	localparam int VW = lkvc_pkg::VAL_W;
	localparam int M_TDATA_WL = lkvc_pkg::M_TDATA_W;

	logic                  req_op_q;
	logic [KEY_BITS-1:0]   req_tag_q;
	logic [VW-1:0]         req_val_q;
	logic [63:0]           key_ext;
	logic [63:0]           tag_ext;
	logic [KW-1:0]         req_key;

	logic [KEY_BITS-1:0]   tag_q [ENTRIES];
	logic [ENTRIES-1:0]    vld_q;
	logic [IW-1:0]         rank_q [ENTRIES];
	logic [OW-1:0]         occ_q;
	logic [lkvc_pkg::CAP_W-1:0] cap_q;
	logic [OW-1:0]         eff_cap;

	logic [KW+VW-1:0]      ent_mem [ENTRIES];
	logic [KW+VW-1:0]      rd_word_q;

	logic [ENTRIES-1:0]    hit_vec_c;
	logic [ENTRIES-1:0]    vic_vec_c;
	logic [ENTRIES-1:0]    hit_vec_s1;
	logic [ENTRIES-1:0]    vic_vec_s1;
	logic                  full_s1;

	logic                  hit_c;
	logic                  evict_c;
	logic [IW-1:0]         hit_idx_c;
	logic [IW-1:0]         vic_idx_c;
	logic [IW-1:0]         hit_rank_c;
	logic [ENTRIES-1:0]    free_vec_c;
	logic [ENTRIES-1:0]    free_oh_c;
	logic [IW-1:0]         free_idx_c;

	logic                  hit_s2;
	logic                  evict_s2;
	logic [IW-1:0]         hit_idx_s2;
	logic [IW-1:0]         hit_rank_s2;
	logic [ENTRIES-1:0]    free_oh_s2;
	logic [IW-1:0]         free_idx_s2;

	logic [M_TDATA_WL-1:0] out_tdata_q;
	logic [lkvc_pkg::M_TUSER_W-1:0] out_tuser_q;
	logic [VW-1:0]         rd_val;
	logic [KW-1:0]         ev_key;

	assign key_ext = 64'(s_tdata[KW-1:0]);
	assign tag_ext = 64'(req_tag_q);
	assign req_key = tag_ext[KW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_op_q  <= s_tuser;
			req_tag_q <= key_ext[KEY_BITS-1:0];
			req_val_q <= s_tdata[KW+VW-1:KW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkvc_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = OW'(1);
		end else if (32'(cap_q) > 32'(ENTRIES)) begin
			eff_cap = OW'(ENTRIES);
		end else begin
			eff_cap = OW'(cap_q);
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec_c[i] = vld_q[i] && (tag_q[i] == req_tag_q);
			vic_vec_c[i] = vld_q[i] && (OW'(rank_q[i]) == occ_q - OW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			hit_vec_s1 <= hit_vec_c;
			vic_vec_s1 <= vic_vec_c;
			full_s1    <= (occ_q >= eff_cap);
		end
	end

	always_comb begin
		hit_idx_c  = '0;
		vic_idx_c  = '0;
		hit_rank_c = '0;
		free_idx_c = '0;
		hit_c      = |hit_vec_s1;
		evict_c    = !hit_c && (req_op_q == lkvc_pkg::OP_SET) && full_s1;
		free_vec_c = ~(vld_q & ~(vic_vec_s1 & {ENTRIES{evict_c}}));
		free_oh_c  = free_vec_c & (~free_vec_c + ENTRIES'(1));
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_vec_s1[i]) begin
				hit_idx_c  = hit_idx_c | IW'(i);
				hit_rank_c = hit_rank_c | rank_q[i];
			end
			if (vic_vec_s1[i]) begin
				vic_idx_c = vic_idx_c | IW'(i);
			end
			if (free_oh_c[i]) begin
				free_idx_c = free_idx_c | IW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			hit_s2      <= hit_c;
			evict_s2    <= evict_c;
			hit_idx_s2  <= hit_idx_c;
			hit_rank_s2 <= hit_rank_c;
			free_oh_s2  <= free_oh_c;
			free_idx_s2 <= free_idx_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_word_q <= ent_mem[hit_c ? hit_idx_c : vic_idx_c];
		end
		if (cmd.upd && (req_op_q == lkvc_pkg::OP_SET)) begin
			ent_mem[hit_s2 ? hit_idx_s2 : free_idx_s2] <= {req_val_q, req_key};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.upd && !hit_s2 && (req_op_q == lkvc_pkg::OP_SET) && free_oh_s2[i]) begin
				tag_q[i] <= req_tag_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			occ_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.upd) begin
			if (hit_s2) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (hit_vec_s1[i]) begin
						rank_q[i] <= '0;
					end else if (vld_q[i] && (rank_q[i] < hit_rank_s2)) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
			end else if (req_op_q == lkvc_pkg::OP_SET) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (free_oh_s2[i]) begin
						vld_q[i]  <= 1'b1;
						rank_q[i] <= '0;
					end else if (evict_s2 && vic_vec_s1[i]) begin
						vld_q[i]  <= 1'b0;
						rank_q[i] <= '0;
					end else if (vld_q[i]) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
				if (!evict_s2) begin
					occ_q <= occ_q + OW'(1);
				end
			end
		end
	end

	assign rd_val = (hit_s2 && (req_op_q == lkvc_pkg::OP_GET)) ? rd_word_q[KW+VW-1:KW] : '0;
	assign ev_key = evict_s2 ? rd_word_q[KW-1:0] : '0;

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			out_tdata_q                       <= {ev_key, rd_val};
			out_tuser_q[lkvc_pkg::TU_HIT]     <= hit_s2;
			out_tuser_q[lkvc_pkg::TU_EVICTED] <= evict_s2;
		end
	end

	assign m_tdata = out_tdata_q;
	assign m_tuser = out_tuser_q;

endmodule
`default_nettype wire

>>> design/lru_key_value_cache_core.sv
// Key-value cache with least-recently-used replacement.
// Slave stream: one get (tuser 0) or set (tuser 1) request per transfer;
//   tdata carries the key in the low word and the set value in the high word.
// Master stream: one result per request; tuser bit 0 is hit, bit 1 is evicted;
//   tdata carries the read value in the low word and the evicted key above it.
// Configuration: cfg_data is the capacity, taken on any cycle with cfg_valid;
//   write it only while no request is in flight.
// Steps: after the request transfer the result passes through tag compare,
//   state lookup with the entry read, and update and result load.
// Flow: the controller walks one request at a time through compare, read
//   and update; a new request is taken only once the last has updated.
// A finished result waits in the output register while the next request is
//   taken; if the receiver stalls, the next request holds in its update step.
// Reset clears all valid marks, the ranks and the fill count, sets capacity
//   to three and leaves both streams empty; no clearing pass is needed.
`default_nettype none
module lru_key_value_cache_core #(
	parameter int ENTRIES  = 8,
	parameter int KEY_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lkvc_pkg::CAP_W-1:0]        cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [lkvc_pkg::S_TDATA_W-1:0]    s_tdata,   // key, value
	input  wire logic                              s_tuser,   // operation
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [lkvc_pkg::M_TDATA_W-1:0]    m_tdata,   // read_value, evicted_key
	output logic      [lkvc_pkg::M_TUSER_W-1:0]    m_tuser    // hit, evicted
);

	lkvc_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	lkvc_dpath #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

>>> tb/sv/tb_lru_key_value_cache_core.sv
`timescale 1ns / 1ps
module tb_lru_key_value_cache_core;

	localparam int KEY_W = lkvc_pkg::KEY_W;
	localparam int VAL_W = lkvc_pkg::VAL_W;
	localparam int CAP_W = lkvc_pkg::CAP_W;
	localparam int S_TDATA_W = lkvc_pkg::S_TDATA_W;
	localparam int M_TDATA_W = lkvc_pkg::M_TDATA_W;
	localparam int M_TUSER_W = lkvc_pkg::M_TUSER_W;
	localparam int TU_HIT = lkvc_pkg::TU_HIT;
	localparam int TU_EVICTED = lkvc_pkg::TU_EVICTED;
	localparam logic [CAP_W-1:0] CAP_RESET = lkvc_pkg::CAP_RESET;
	localparam logic OP_GET = lkvc_pkg::OP_GET;
	localparam logic OP_SET = lkvc_pkg::OP_SET;

	localparam int SLOTS = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
	} lookup_result_t;

	typedef struct packed {
		logic             op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic             known;
		lookup_result_t   answer;
	} plan_row_t;

	localparam plan_row_t directed_plan [21] = '{
		'{OP_GET, 32'h00000000, 32'h00000000, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
		'{OP_SET, 32'h00000000, 32'hFFFFFFFF, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
		'{OP_GET, 32'h00000000, 32'h00000000, 1'b1, '{1'b1, 32'hFFFFFFFF, 1'b0, 32'h0}},
		'{OP_SET, 32'hFFFFFFFF, 32'h00000000, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
		'{OP_SET, 32'h00000001, 32'h00000001, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
		'{OP_SET, 32'h00000002, 32'h00000002, 1'b1, '{1'b0, 32'h0, 1'b1, 32'h0}},
		'{OP_GET, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{1'b1, 32'h0, 1'b0, 32'h0}},
		'{OP_SET, 32'h00000003, 32'h00000003, 1'b1, '{1'b0, 32'h0, 1'b1, 32'h1}},
		'{OP_SET, 32'hFFFFFFFF, 32'hA5A5A5A5, 1'b1, '{1'b1, 32'h0, 1'b0, 32'h0}},
		'{OP_GET, 32'hFFFFFFFF, 32'h00000000, 1'b1, '{1'b1, 32'hA5A5A5A5, 1'b0, 32'h0}},
		'{OP_GET, 32'h00000000, 32'h00000000, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
		'{OP_SET, 32'h80000000, 32'h5A5A5A5A, 1'b1, '{1'b0, 32'h0, 1'b1, 32'h2}},
		'{OP_GET, 32'h80000000, 32'h00000000, 1'b1, '{1'b1, 32'h5A5A5A5A, 1'b0, 32'h0}},
		'{OP_SET, 32'h7FFFFFFF, 32'h12345678, 1'b1, '{1'b0, 32'h0, 1'b1, 32'h3}},
		'{OP_GET, 32'h00000003, 32'h00000000, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
		'{OP_SET, 32'hFFFFFFFE, 32'hFFFFFFFF, 1'b1, '{1'b0, 32'h0, 1'b1, 32'hFFFFFFFF}},
		'{OP_GET, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, '{1'b1, 32'h12345678, 1'b0, 32'h0}},
		'{OP_SET, 32'h7FFFFFFF, 32'h00000000, 1'b0, '0},
		'{OP_GET, 32'h80000000, 32'h00000000, 1'b0, '0},
		'{OP_SET, 32'hDEADBEEF, 32'h00000000, 1'b0, '0},
		'{OP_GET, 32'hFFFFFFFE, 32'h00000000, 1'b0, '0}
	};

	localparam logic [CAP_W-1:0] capacity_plan [RANDOM_PHASES] = '{
		4'd8, 4'd1, 4'd0, 4'd15, 4'd8, 4'd2, 4'd9, 4'd5, 4'd3, 4'd7
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CAP_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // key, value
	logic                 s_tuser = 1'b0; // operation
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // read_value, evicted_key
	logic [M_TUSER_W-1:0] m_tuser;        // hit, evicted

	logic [KEY_W-1:0] slot_key [SLOTS];
	logic [VAL_W-1:0] slot_value [SLOTS];
	logic             slot_live [SLOTS];
	int unsigned      slot_age [SLOTS];
	int unsigned      live_count;
	logic [CAP_W-1:0] capacity_reg;

	lookup_result_t pending_results [$];
	int  mismatch_count = 0;
	bit  tx_idle = 1'b1;
	bit  rx_idle = 1'b1;
	int  rx_hold = 0;

	lru_key_value_cache_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic lookup_result_t apply_request(logic op, logic [KEY_W-1:0] key,
			logic [VAL_W-1:0] value);
		lookup_result_t res;
		int found;
		int victim;
		int free_slot;
		int unsigned limit;
		int unsigned oldest;
		int unsigned rank;
		res = '0;
		found = -1;
		for (int i = 0; i < SLOTS; i++)
			if (found < 0 && slot_live[i] && slot_key[i] == key)
				found = i;
		if (found >= 0) begin
			res.hit = 1'b1;
			if (op == OP_GET)
				res.read_value = slot_value[found];
			else
				slot_value[found] = value;
			rank = slot_age[found];
			for (int i = 0; i < SLOTS; i++)
				if (slot_live[i] && slot_age[i] < rank)
					slot_age[i]++;
			slot_age[found] = 0;
		end else if (op == OP_SET) begin
			limit = (capacity_reg == 0) ? 1 : (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
			if (live_count >= limit) begin
				victim = -1;
				oldest = 0;
				for (int i = 0; i < SLOTS; i++)
					if (slot_live[i] && (victim < 0 || slot_age[i] > oldest)) begin
						victim = i;
						oldest = slot_age[i];
					end
				if (victim >= 0) begin
					res.evicted = 1'b1;
					res.evicted_key = slot_key[victim];
					slot_live[victim] = 1'b0;
					slot_age[victim] = 0;
					live_count--;
				end
			end
			free_slot = -1;
			for (int i = 0; i < SLOTS; i++)
				if (free_slot < 0 && !slot_live[i])
					free_slot = i;
			if (free_slot >= 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (slot_live[i])
						slot_age[i]++;
				slot_live[free_slot] = 1'b1;
				slot_key[free_slot] = key;
				slot_value[free_slot] = value;
				slot_age[free_slot] = 0;
				live_count++;
			end
		end
		return res;
	endfunction

	task automatic offer_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
			logic known, lookup_result_t answer);
		int gap;
		lookup_result_t predicted;
		gap = tx_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {value, key};
		do @(posedge clk); while (!s_tready);
		predicted = apply_request(op, key, value);
		pending_results.push_back(known ? answer : predicted);
	endtask

	task automatic drain_results(int settle);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		drain_results(SETTLE_CYCLES);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		capacity_reg = cap;
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
		end
	endtask

	// result sink: random stalls, plus one long hold when asked
	initial begin
		int gap;
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			gap = rx_idle ? $urandom_range(0, 11) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		lookup_result_t want;
		lookup_result_t got;
		if (m_tvalid && m_tready) begin
			got = '{m_tuser[TU_HIT], m_tdata[VAL_W-1:0], m_tuser[TU_EVICTED],
				m_tdata[M_TDATA_W-1:VAL_W]};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected transfer: expected none actual %h", $time, got);
			end else begin
				want = pending_results.pop_front();
				check_field("hit", 32'(want.hit), 32'(got.hit));
				check_field("read_value", want.read_value, got.read_value);
				check_field("evicted", 32'(want.evicted), 32'(got.evicted));
				check_field("evicted_key", want.evicted_key, got.evicted_key);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL lru_key_value_cache_core");
		$finish;
	end

	initial begin
		logic [KEY_W-1:0] key_pool [16];
		int pool_size;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic op;
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_age[i] = 0;
		end
		live_count = 0;
		capacity_reg = CAP_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_plan[i])
			offer_request(directed_plan[i].op, directed_plan[i].key, directed_plan[i].value,
				directed_plan[i].known, directed_plan[i].answer);
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_capacity(capacity_plan[ph]);
			tx_idle = (ph % 3) != 1;
			rx_idle = (ph % 4) != 2;
			pool_size = $urandom_range(2, 16);
			for (int k = 0; k < pool_size; k++) begin
				key_pool[k] = $urandom();
				// near neighbours: keys one bit apart must not alias
				if (k > 0 && $urandom_range(0, 3) == 0)
					key_pool[k] = key_pool[$urandom_range(0, k - 1)]
						^ (32'h1 << $urandom_range(0, 31));
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == 60)
					rx_hold = LONG_HOLD;
				if (ph == 5 && n == 100)
					drain_results(0);
				op = 1'($urandom_range(0, 1));
				key = ($urandom_range(0, 9) == 0) ? $urandom()
					: key_pool[$urandom_range(0, pool_size - 1)];
				value = $urandom();
				offer_request(op, key, value, 1'b0, '0);
			end
		end
		drain_results(SETTLE_CYCLES);
		if (mismatch_count == 0)
			$display("PASS lru_key_value_cache_core");
		else
			$display("FAIL lru_key_value_cache_core");
		$finish;
	end

endmodule
